// File: hw/rtl/wfr_pkg.sv
// shared types, constants and the colour ramp for the waterfall row store
// no dependencies; imported by the interfaces, the colour map, the top level and the testbench
`default_nettype none

package wfr_pkg;

	localparam int CFG_W       = 11;
	localparam int ROW_WIDTH_W = 11;
	localparam int DISP_ROWS_W = 9;
	localparam int SAMPLE_W    = 24;
	localparam int ROW_W       = 9;
	localparam int COLUMN_W    = 10;
	localparam int CHAN_W      = 8;
	localparam int TERM_W      = 28;

	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 11'd1024;
	localparam logic [DISP_ROWS_W-1:0] DISP_ROWS_RST = 9'd500;

	// command word actions
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// q8.16 constants
	localparam logic signed [TERM_W-1:0] ONE_Q   = 28'sd65536;
	localparam logic signed [TERM_W-1:0] HALF_Q  = 28'sd32768;
	localparam logic signed [TERM_W-1:0] THREE_Q = 28'sd196608;

	typedef enum logic [0:0] {
		REG_ROW_WIDTH    = 1'b0,
		REG_DISPLAY_ROWS = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	localparam int PIXEL_W = $bits(pixel_t);

	// colour of a zero sample: red 0, green 255, blue 255
	localparam pixel_t ZERO_COLOUR = '{red: 8'd0, green: 8'd255, blue: 8'd255};
	localparam pixel_t BLACK       = '{red: 8'd0, green: 8'd0, blue: 8'd0};

	// clamp to 0..1 in q16, scale by 255 and truncate
	function automatic logic [CHAN_W-1:0] ramp(input logic signed [TERM_W-1:0] t);
		logic [16:0] c;
		logic [24:0] p;
		if (t < 0) begin
			c = 17'd0;
		end else if (t > ONE_Q) begin
			c = 17'h10000;
		end else begin
			c = t[16:0];
		end
		p = {c, 8'd0} - {8'd0, c};
		return p[23:16];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/wfr_if.sv
// valid/ready channels of the waterfall row store: command words in, result words out
// depends on wfr_pkg
`default_nettype none

interface wfr_cmd_if import wfr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic signed [SAMPLE_W-1:0] sample;
	logic [ROW_W-1:0]           row;
	logic [COLUMN_W-1:0]        column;

	modport source (output valid, action, sample, row, column, input ready);
	modport sink (input valid, action, sample, row, column, output ready);
endinterface

interface wfr_rsp_if import wfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              row_complete;
	logic              out_of_range;

	modport source (output valid, red, green, blue, row_complete, out_of_range, input ready);
	modport sink (input valid, red, green, blue, row_complete, out_of_range, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/wfr_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module wfr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/wfr_cmap.sv
// three-ramp colour map: signed q8.16 sample to 8-bit rgb
// depends on wfr_pkg
`default_nettype none

module wfr_cmap import wfr_pkg::*; (
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output      pixel_t                     pixel
);

	logic signed [TERM_W-1:0] sx;
	logic signed [TERM_W-1:0] d;
	logic signed [TERM_W-1:0] dabs;

	always_comb begin
		sx   = TERM_W'(sample);
		d    = sx - HALF_Q;
		dabs = (d < 0) ? -d : d;
		pixel.blue  = ramp(THREE_Q - (sx <<< 2));
		pixel.red   = ramp((sx <<< 2) - ONE_Q);
		pixel.green = ramp((dabs <<< 2) - ONE_Q);
	end

endmodule

`default_nettype wire

// File: hw/rtl/waterfall_row_store_colormap.sv
// Scrolling spectrogram waterfall store. One command word is taken per clock, if the
// output is not stalled, and yields a result; the rate is one word per clock, set by
// the pixel ram, which takes one write (push) and one registered read (pixel read)
// per cycle. A push writes the mapped colour into the next column of the row being
// built; the row that completes becomes display row 0. Rows not yet filled read as
// the colour of zero, tracked by a fill counter, so the ram needs no clearing pass
// after reset. A stalled output holds the whole two-stage pipe.
// depends on wfr_pkg, wfr_if, wfr_ram, wfr_cmap
`default_nettype none

module waterfall_row_store_colormap import wfr_pkg::*; #(
	parameter int ROW_SLOTS = 512,
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write,
	input  wire reg_index_t       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	wfr_cmd_if.sink               cmd,
	wfr_rsp_if.source             rsp
);

	localparam int SLOT_W = $clog2(ROW_SLOTS);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int DEPTH  = ROW_SLOTS * MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W  = ((WID_W > ROW_WIDTH_W) ? WID_W : ROW_WIDTH_W) + 1;
	localparam int RC_W   = ((SLOT_W > ROW_W) ? SLOT_W : ROW_W) + 1;

	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [DISP_ROWS_W-1:0] display_rows_q;
	logic [SLOT_W-1:0]      newest_slot_q;
	logic [COL_W-1:0]       fill_column_q;
	logic [SLOT_W-1:0]      rows_filled_q;

	// accept stage
	logic              en;
	logic              acc;
	logic [CMP_W-1:0]  rw_ext;
	logic [CMP_W-1:0]  eff_width;
	logic [RC_W-1:0]   dr_ext;
	logic [RC_W-1:0]   eff_rows;
	logic [RC_W-1:0]   row_ext;
	logic [RC_W-1:0]   n_ext;
	logic [RC_W-1:0]   back;
	logic [CMP_W-1:0]  fill_next;
	logic              row_done;
	logic [SLOT_W-1:0] next_slot;
	logic              rd_oor;
	logic              rd_zero;

	// stage 1
	logic                       valid_s1;
	logic                       push_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [SLOT_W-1:0]          slot_s1;
	logic [COL_W-1:0]           col_s1;
	logic                       done_s1;
	logic                       oor_s1;
	logic                       zero_s1;
	logic [ADDR_W-1:0]          addr_s1;
	pixel_t                     colour_s1;
	logic                       ram_we;
	logic                       ram_re;

	// stage 2
	logic   valid_s2;
	logic   done_s2;
	logic   oor_s2;
	logic   zero_s2;
	logic   mem_s2;
	pixel_t rdata;
	pixel_t pix_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q    <= ROW_WIDTH_RST;
			display_rows_q <= DISP_ROWS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROW_WIDTH:    row_width_q    <= cfg_data;
				REG_DISPLAY_ROWS: display_rows_q <= cfg_data[DISP_ROWS_W-1:0];
				default:          ;
			endcase
		end
	end

	assign en        = !valid_s2 || rsp.ready;
	assign cmd.ready = en;
	assign acc       = cmd.valid && en;

	always_comb begin
		rw_ext = CMP_W'(row_width_q);
		if (rw_ext == '0) begin
			eff_width = CMP_W'(1);
		end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
			eff_width = CMP_W'(MAX_WIDTH);
		end else begin
			eff_width = rw_ext;
		end
		dr_ext   = RC_W'(display_rows_q);
		eff_rows = (dr_ext > RC_W'(ROW_SLOTS - 1)) ? RC_W'(ROW_SLOTS - 1) : dr_ext;

		fill_next = CMP_W'(fill_column_q) + CMP_W'(1);
		row_done  = fill_next >= eff_width;
		next_slot = (newest_slot_q == SLOT_W'(ROW_SLOTS - 1)) ? '0 : newest_slot_q + 1'b1;

		row_ext = RC_W'(cmd.row);
		n_ext   = RC_W'(newest_slot_q);
		rd_oor  = (row_ext >= eff_rows) || (CMP_W'(cmd.column) >= eff_width);
		rd_zero = row_ext >= RC_W'(rows_filled_q);
		// ring walks backwards from the newest slot
		back = (n_ext >= row_ext) ? n_ext - row_ext : n_ext + RC_W'(ROW_SLOTS) - row_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_slot_q <= '0;
			fill_column_q <= '0;
			rows_filled_q <= '0;
		end else if (acc && (cmd.action == ACT_PUSH)) begin
			if (row_done) begin
				newest_slot_q <= next_slot;
				fill_column_q <= '0;
				if (rows_filled_q != SLOT_W'(ROW_SLOTS - 1)) begin
					rows_filled_q <= rows_filled_q + 1'b1;
				end
			end else begin
				fill_column_q <= fill_column_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			push_s1   <= (cmd.action == ACT_PUSH);
			sample_s1 <= cmd.sample;
			slot_s1   <= (cmd.action == ACT_READ) ? back[SLOT_W-1:0] : next_slot;
			col_s1    <= (cmd.action == ACT_READ) ? COL_W'(cmd.column) : fill_column_q;
			done_s1   <= (cmd.action == ACT_PUSH) && row_done;
			oor_s1    <= (cmd.action == ACT_READ) && rd_oor;
			zero_s1   <= (cmd.action == ACT_READ) && !rd_oor && rd_zero;
		end
	end

	wfr_cmap u_cmap (
		.sample (sample_s1),
		.pixel  (colour_s1)
	);

	assign addr_s1 = ADDR_W'(slot_s1) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_s1);
	assign ram_we  = en && valid_s1 && push_s1;
	assign ram_re  = en && valid_s1 && !push_s1 && !oor_s1 && !zero_s1;

	wfr_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (colour_s1),
		.re    (ram_re),
		.raddr (addr_s1),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			done_s2 <= done_s1;
			oor_s2  <= oor_s1;
			zero_s2 <= zero_s1;
			mem_s2  <= !push_s1 && !oor_s1 && !zero_s1;
		end
	end

	// ram output holds while stalled since no read is issued then
	always_comb begin
		if (mem_s2) begin
			pix_out = rdata;
		end else if (zero_s2) begin
			pix_out = ZERO_COLOUR;
		end else begin
			pix_out = BLACK;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.red          = pix_out.red;
	assign rsp.green        = pix_out.green;
	assign rsp.blue         = pix_out.blue;
	assign rsp.row_complete = done_s2;
	assign rsp.out_of_range = oor_s2;

	a_slot_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (cmd.action == ACT_PUSH) && row_done)
			|=> (newest_slot_q != $past(newest_slot_q)))
		else $error("newest slot did not advance on row completion");

	a_filled_moves_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rows_filled_q != $past(rows_filled_q))
			|-> $past(acc && (cmd.action == ACT_PUSH) && row_done))
		else $error("fill count changed without a completed row");

	a_s2_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({mem_s2, zero_s2, oor_s2, done_s2}))
		else $error("result word has conflicting kinds");

	a_write_not_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ram written and read by the same word");

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for the waterfall row store: pushes spectrum samples, reads pixels
// back and checks every result word against an in-bench model of the colour map and row ring
// depends on wfr_pkg, wfr_if and waterfall_row_store_colormap
module tb import wfr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS      = 512;
	localparam int MAX_W      = 1024;
	localparam int QUIET_MAX  = 500;
	localparam longint UNIT_Q = 65536;

	typedef struct {
		logic                       action;
		logic signed [SAMPLE_W-1:0] sample;
		logic [ROW_W-1:0]           row;
		logic [COLUMN_W-1:0]        column;
	} waterfall_cmd_t;

	typedef struct {
		pixel_t colour;
		logic   row_complete;
		logic   out_of_range;
	} waterfall_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_write;
	reg_index_t       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	wfr_cmd_if cmd_ch ();
	wfr_rsp_if rsp_ch ();

	waterfall_row_store_colormap #(
		.ROW_SLOTS(SLOTS),
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch)
	);

	always #5 clk = ~clk;

	// model of the store: ring of rows, registers and the awaited result words
	pixel_t                     pixel_mem [int];
	int                         newest_slot = 0;
	int                         fill_col    = 0;
	int                         rows_done   = 0;
	logic [ROW_WIDTH_W-1:0]     width_reg   = ROW_WIDTH_RST;
	logic [DISP_ROWS_W-1:0]     rows_reg    = DISP_ROWS_RST;
	waterfall_result_t          awaited_words [$];

	bit steady = 1'b0;
	int fail_count = 0;
	int push_count = 0, read_count = 0, rows_count = 0, oor_count = 0, blank_count = 0;

	function automatic int draw_wait();
		return steady ? 0 : int'($urandom_range(0, 16));
	endfunction

	function automatic int live_width();
		int w;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int live_rows();
		int r;
		r = rows_reg;
		if (r > SLOTS - 1) r = SLOTS - 1;
		return r;
	endfunction

	function automatic int slot_of_row(input int r);
		return (newest_slot + SLOTS - r) % SLOTS;
	endfunction

	function automatic logic [CHAN_W-1:0] clamp_scale(input longint t);
		if (t < 0) t = 0;
		if (t > UNIT_Q) t = UNIT_Q;
		return CHAN_W'((t * 255) / UNIT_Q);
	endfunction

	// three clamped ramps on the q8.16 value
	function automatic pixel_t colour_of_sample(input logic signed [SAMPLE_W-1:0] s);
		longint x, d;
		pixel_t p;
		x = s;
		d = x - UNIT_Q / 2;
		if (d < 0) d = -d;
		p.blue  = clamp_scale(3 * UNIT_Q - 4 * x);
		p.red   = clamp_scale(4 * x - UNIT_Q);
		p.green = clamp_scale(4 * d - UNIT_Q);
		return p;
	endfunction

	function automatic waterfall_result_t predict_word(input waterfall_cmd_t c);
		waterfall_result_t res;
		int slot;
		res.colour       = BLACK;
		res.row_complete = 1'b0;
		res.out_of_range = 1'b0;
		if (c.action == ACT_PUSH) begin
			push_count++;
			slot = (newest_slot + 1) % SLOTS;
			pixel_mem[slot * MAX_W + fill_col] = colour_of_sample(c.sample);
			if (fill_col + 1 >= live_width()) begin
				newest_slot = slot;
				fill_col = 0;
				if (rows_done < SLOTS - 1) rows_done++;
				res.row_complete = 1'b1;
				rows_count++;
			end else begin
				fill_col++;
			end
		end else begin
			read_count++;
			if (c.row >= live_rows() || c.column >= live_width()) begin
				res.out_of_range = 1'b1;
				oor_count++;
			end else if (c.row >= rows_done) begin
				res.colour = ZERO_COLOUR;
				blank_count++;
			end else begin
				res.colour = pixel_mem[slot_of_row(c.row) * MAX_W + c.column];
			end
		end
		return res;
	endfunction

	// an older, narrower row has nothing beyond its width: fall back to column 0
	function automatic waterfall_cmd_t keep_to_written(input waterfall_cmd_t c);
		if (c.row < live_rows() && c.column < live_width() && c.row < rows_done &&
				!pixel_mem.exists(slot_of_row(c.row) * MAX_W + c.column))
			c.column = '0;
		return c;
	endfunction

	function automatic waterfall_cmd_t push_cmd(input logic signed [SAMPLE_W-1:0] s);
		waterfall_cmd_t c;
		c.action = ACT_PUSH;
		c.sample = s;
		c.row    = ROW_W'($urandom);
		c.column = COLUMN_W'($urandom);
		return c;
	endfunction

	function automatic waterfall_cmd_t read_cmd(input int r, input int col);
		waterfall_cmd_t c;
		c.action = ACT_READ;
		c.sample = SAMPLE_W'($urandom);
		c.row    = ROW_W'(r);
		c.column = COLUMN_W'(col);
		return c;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int v;
		case ($urandom_range(0, 2))
			0: v = $urandom;
			1: v = $urandom_range(0, 65536);
			default: v = int'($urandom_range(0, 81920)) - 8192;
		endcase
		return SAMPLE_W'(v);
	endfunction

	function automatic waterfall_cmd_t random_read();
		int pick, vis, w, filled;
		pick   = $urandom_range(0, 99);
		vis    = live_rows();
		w      = live_width();
		filled = (rows_done < vis) ? rows_done : vis;
		if (pick < 65 && filled > 0)
			return read_cmd($urandom_range(0, filled - 1), $urandom_range(0, w - 1));
		if (pick < 80 && vis > rows_done)
			return read_cmd($urandom_range(rows_done, vis - 1), $urandom_range(0, w - 1));
		return read_cmd($urandom_range(0, SLOTS - 1), $urandom_range(0, MAX_W - 1));
	endfunction

	task automatic send_word(input waterfall_cmd_t c);
		int gap;
		if (c.action == ACT_READ) c = keep_to_written(c);
		gap = draw_wait();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.action <= c.action;
		cmd_ch.sample <= c.sample;
		cmd_ch.row    <= c.row;
		cmd_ch.column <= c.column;
		do @(posedge clk); while (!cmd_ch.ready);
		awaited_words.push_back(predict_word(c));
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
	endtask

	// both registers, one after the other, only while nothing is in flight
	task automatic set_geometry(input int width, input int rows);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= REG_ROW_WIDTH;
		cfg_data  <= CFG_W'(width);
		@(posedge clk);
		cfg_index <= REG_DISPLAY_ROWS;
		cfg_data  <= CFG_W'(rows);
		@(posedge clk);
		cfg_write <= 1'b0;
		width_reg = ROW_WIDTH_W'(width);
		rows_reg  = DISP_ROWS_W'(rows);
	endtask

	task automatic test_reset_defaults();
		send_word(read_cmd(0, MAX_W - 1));
		send_word(read_cmd(499, 0));
		send_word(read_cmd(500, 0));
	endtask

	task automatic test_colour_extremes();
		set_geometry(0, 511);
		steady = 1'b1;
		send_word(push_cmd(24'sh800000));
		send_word(push_cmd(-24'sd1));
		send_word(push_cmd(24'sd0));
		send_word(push_cmd(24'sd16384));
		send_word(push_cmd(24'sd32768));
		send_word(push_cmd(24'sd49152));
		send_word(push_cmd(24'sd65536));
		send_word(push_cmd(24'sd98304));
		send_word(push_cmd(24'sh7fffff));
		steady = 1'b0;
		send_word(read_cmd(0, 0));
		send_word(read_cmd(4, 0));
		send_word(read_cmd(8, 0));
		send_word(read_cmd(0, 1));
	endtask

	task automatic test_no_rows();
		set_geometry(3, 0);
		send_word(read_cmd(0, 0));
	endtask

	task automatic test_width_shrink();
		set_geometry(8, 511);
		repeat (5) send_word(push_cmd(random_sample()));
		set_geometry(2, 511);
		send_word(push_cmd(random_sample()));
		send_word(read_cmd(0, 1));
	endtask

	task automatic test_oversize_width();
		set_geometry(2047, 300);
		send_word(read_cmd(299, MAX_W - 1));
		send_word(read_cmd(0, 0));
	endtask

	task automatic run_phase(input int width, input int rows, input int count,
			input int push_pct);
		set_geometry(width, rows);
		steady = ($urandom_range(0, 3) == 0);
		repeat (count) begin
			if ($urandom_range(0, 99) < push_pct) send_word(push_cmd(random_sample()));
			else send_word(random_read());
		end
	endtask

	// one-column rows fill the whole ring and wrap it
	task automatic test_ring_wrap();
		run_phase(1, 511, 640, 85);
	endtask

	task automatic test_random_geometry();
		int width, rows;
		repeat (10) begin
			case ($urandom_range(0, 9))
				0: width = 0;
				1: width = 2047;
				2: width = MAX_W;
				3: width = $urandom_range(17, 64);
				default: width = $urandom_range(1, 16);
			endcase
			case ($urandom_range(0, 5))
				0: rows = 0;
				1: rows = 1;
				2: rows = 511;
				default: rows = $urandom_range(2, 510);
			endcase
			run_phase(width, rows, 100, 60);
		end
	endtask

	initial begin : rsp_stall
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	always @(posedge clk) begin : check_words
		waterfall_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_words.size() == 0) begin
				$error("result word with nothing awaited");
				fail_count++;
			end else begin
				want = awaited_words.pop_front();
				if (rsp_ch.red !== want.colour.red) begin
					$error("red: expected %0d, got %0d", want.colour.red, rsp_ch.red);
					fail_count++;
				end
				if (rsp_ch.green !== want.colour.green) begin
					$error("green: expected %0d, got %0d", want.colour.green, rsp_ch.green);
					fail_count++;
				end
				if (rsp_ch.blue !== want.colour.blue) begin
					$error("blue: expected %0d, got %0d", want.colour.blue, rsp_ch.blue);
					fail_count++;
				end
				if (rsp_ch.row_complete !== want.row_complete) begin
					$error("row_complete: expected %0b, got %0b", want.row_complete,
						rsp_ch.row_complete);
					fail_count++;
				end
				if (rsp_ch.out_of_range !== want.out_of_range) begin
					$error("out_of_range: expected %0b, got %0b", want.out_of_range,
						rsp_ch.out_of_range);
					fail_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_MAX) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_write)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no word moved for %0d cycles", QUIET_MAX);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = REG_ROW_WIDTH;
		cfg_data      = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.action = ACT_PUSH;
		cmd_ch.sample = '0;
		cmd_ch.row    = '0;
		cmd_ch.column = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_colour_extremes();
		test_no_rows();
		test_width_shrink();
		test_oversize_width();
		test_ring_wrap();
		test_random_geometry();

		wait_idle();
		repeat (4) @(posedge clk);
		$display("covered %0d pushes completing %0d rows, %0d reads", push_count, rows_count,
			read_count);
		$display("of the reads %0d out of range and %0d of unfilled rows", oor_count,
			blank_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/wfr_pkg.sv
hw/rtl/wfr_if.sv
hw/rtl/wfr_ram.sv
hw/rtl/wfr_cmap.sv
hw/rtl/waterfall_row_store_colormap.sv
tb/tb.sv
